[rtl/irbg_pkg.sv]
package irbg_pkg;

	localparam int WORDS_DEF     = 256;
	localparam int LOG_WORDS_DEF = 8;
	localparam int MAX_BURST_DEF = 64;

	localparam logic [31:0] GOLDEN = 32'h9e3779b9;

	localparam logic [1:0] CMD_SEED  = 2'd0;
	localparam logic [1:0] CMD_RESEED = 2'd1;
	localparam logic [1:0] CMD_GEN   = 2'd2;
	localparam logic [1:0] CMD_UNUSED = 2'd3;

	typedef logic [7:0][31:0] v8_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_XOR_WR,
		ST_RS_INIT,
		ST_RS_LOAD,
		ST_RS_MIX,
		ST_RS_STORE,
		ST_RND_START,
		ST_RD_X,
		ST_RD_H,
		ST_RD_I,
		ST_WR_Y,
		ST_RD_Y,
		ST_WR_B,
		ST_GEN_RD,
		ST_GEN_OUT
	} state_t;

	// one line of the eight-word init mix
	function automatic v8_t mix_step(v8_t v, logic [2:0] k);
		v8_t r;
		logic [2:0] k1;
		logic [2:0] k2;
		logic [2:0] k3;
		logic [31:0] sh;
		k1 = k + 3'd1;
		k2 = k + 3'd2;
		k3 = k + 3'd3;
		case (k)
			3'd0: sh = v[k1] << 11;
			3'd1: sh = v[k1] >> 2;
			3'd2: sh = v[k1] << 8;
			3'd3: sh = v[k1] >> 16;
			3'd4: sh = v[k1] << 10;
			3'd5: sh = v[k1] >> 4;
			3'd6: sh = v[k1] << 8;
			default: sh = v[k1] >> 9;
		endcase
		r = v;
		r[k] = v[k] ^ sh;
		r[k3] = v[k3] + r[k];
		r[k1] = v[k1] + v[k2];
		return r;
	endfunction

	// accumulator shift of one round step
	function automatic logic [31:0] round_mix(logic [31:0] a, logic [1:0] ph);
		logic [31:0] m;
		case (ph)
			2'd0: m = a << 13;
			2'd1: m = a >> 6;
			2'd2: m = a << 2;
			default: m = a >> 16;
		endcase
		return a ^ m;
	endfunction

endpackage

[rtl/isaac_random_byte_generator_top.sv]
// Byte generator: a generate beat reads each byte from the result buffer and
// presents it, held while out_stall is high; a buffer refill is one ISAAC
// round, word by word, bound by the single read port of the state memory.
// A seed beat XORs seed_word into a buffer word; a reseed mixes in two passes.
// Reset clears control, accumulators and the result buffer valid bits
// (unwritten buffer words read as zero); the state memory is not cleared.
module isaac_random_byte_generator_top #(
	parameter int WORDS     = irbg_pkg::WORDS_DEF,
	parameter int LOG_WORDS = irbg_pkg::LOG_WORDS_DEF,
	parameter int MAX_BURST = irbg_pkg::MAX_BURST_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  command,
	input  logic [31:0] seed_word,
	input  logic [7:0]  word_index,
	input  logic [6:0]  byte_count,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [7:0]  data_byte,
	output logic        last
);

	localparam int PW = LOG_WORDS + 3;
	localparam logic [PW-1:0] POS_END = PW'(WORDS * 4);
	localparam logic [LOG_WORDS-1:0] LAST_W = LOG_WORDS'(WORDS - 1);
	localparam logic [LOG_WORDS-1:0] LAST_G = LOG_WORDS'(WORDS - 8);
	localparam logic [LOG_WORDS-1:0] HALF_W = LOG_WORDS'(WORDS / 2);
	localparam logic [6:0] BURST = 7'(MAX_BURST);

	irbg_pkg::state_t state_q, state_d;

	logic [LOG_WORDS-1:0] ptr_q;
	logic [3:0]           k_q;
	logic [4:0]           mix_q;
	logic                 pass_q;
	logic [31:0]          a_q, b_q, rc_q, x_q, y_q, seed_q;
	irbg_pkg::v8_t        v_q;
	logic [PW-1:0]        pos_q;
	logic [6:0]           cnt_q;
	logic [LOG_WORDS-1:0] widx_q;
	logic [7:0]           out_byte_q;
	logic                 out_last_q, out_valid_q;

	// memories
	logic [31:0] sm_mem [WORDS];
	logic [31:0] rb_mem [WORDS];
	logic [WORDS-1:0] rb_vld_q;
	logic [31:0] sm_rd_q, rb_rd_q;
	logic        rb_rdv_q;

	logic                 sm_re, sm_we, rb_re, rb_we;
	logic [LOG_WORDS-1:0] sm_raddr, sm_waddr, rb_raddr, rb_waddr;
	logic [31:0]          sm_wdata, rb_wdata, rb_data, src_data, y_new, b_new;
	logic                 in_acc, out_load;
	logic [6:0]           cnt_in;

	assign in_stall  = (state_q != irbg_pkg::ST_IDLE);
	assign in_acc    = in_valid && !in_stall;
	assign out_load  = (state_q == irbg_pkg::ST_GEN_OUT) && (!out_valid_q || !out_stall);
	assign rb_data   = rb_rdv_q ? rb_rd_q : 32'd0;
	assign src_data  = pass_q ? sm_rd_q : rb_data;
	assign y_new     = sm_rd_q + a_q + b_q;
	assign b_new     = sm_rd_q + x_q;
	assign cnt_in    = (byte_count > BURST) ? BURST : byte_count;
	assign out_valid = out_valid_q;
	assign data_byte = out_byte_q;
	assign last      = out_last_q;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			irbg_pkg::ST_IDLE: begin
				if (in_acc) begin
					case (command)
						irbg_pkg::CMD_SEED:   state_d = irbg_pkg::ST_XOR_WR;
						irbg_pkg::CMD_RESEED: state_d = irbg_pkg::ST_RS_INIT;
						irbg_pkg::CMD_GEN:
							state_d = (cnt_in != 7'd0) ? irbg_pkg::ST_GEN_RD : irbg_pkg::ST_IDLE;
						default: state_d = irbg_pkg::ST_IDLE;
					endcase
				end
			end
			irbg_pkg::ST_XOR_WR: state_d = irbg_pkg::ST_IDLE;
			irbg_pkg::ST_RS_INIT: if (mix_q == 5'd31) state_d = irbg_pkg::ST_RS_LOAD;
			irbg_pkg::ST_RS_LOAD: if (k_q == 4'd8) state_d = irbg_pkg::ST_RS_MIX;
			irbg_pkg::ST_RS_MIX: if (mix_q[2:0] == 3'd7) state_d = irbg_pkg::ST_RS_STORE;
			irbg_pkg::ST_RS_STORE: begin
				if (k_q == 4'd7) begin
					state_d = (ptr_q == LAST_G && pass_q) ? irbg_pkg::ST_IDLE
					                                      : irbg_pkg::ST_RS_LOAD;
				end
			end
			irbg_pkg::ST_RND_START: state_d = irbg_pkg::ST_RD_X;
			irbg_pkg::ST_RD_X: state_d = irbg_pkg::ST_RD_H;
			irbg_pkg::ST_RD_H: state_d = irbg_pkg::ST_RD_I;
			irbg_pkg::ST_RD_I: state_d = irbg_pkg::ST_WR_Y;
			irbg_pkg::ST_WR_Y: state_d = irbg_pkg::ST_RD_Y;
			irbg_pkg::ST_RD_Y: state_d = irbg_pkg::ST_WR_B;
			irbg_pkg::ST_WR_B:
				state_d = (ptr_q == LAST_W) ? irbg_pkg::ST_GEN_RD : irbg_pkg::ST_RD_X;
			irbg_pkg::ST_GEN_RD:
				state_d = (pos_q == POS_END) ? irbg_pkg::ST_RND_START : irbg_pkg::ST_GEN_OUT;
			irbg_pkg::ST_GEN_OUT: begin
				if (out_load) state_d = (cnt_q == 7'd1) ? irbg_pkg::ST_IDLE : irbg_pkg::ST_GEN_RD;
			end
			default: state_d = irbg_pkg::ST_IDLE;
		endcase
	end

	// memory port control
	always_comb begin
		sm_re = 1'b0; sm_raddr = ptr_q;
		sm_we = 1'b0; sm_waddr = ptr_q; sm_wdata = y_new;
		rb_re = 1'b0; rb_raddr = ptr_q;
		rb_we = 1'b0; rb_waddr = ptr_q; rb_wdata = b_new;
		case (state_q)
			irbg_pkg::ST_IDLE: begin
				rb_re    = in_acc && (command == irbg_pkg::CMD_SEED);
				rb_raddr = word_index[LOG_WORDS-1:0];
			end
			irbg_pkg::ST_XOR_WR: begin
				rb_we    = 1'b1;
				rb_waddr = widx_q;
				rb_wdata = rb_data ^ seed_q;
			end
			irbg_pkg::ST_RS_LOAD: begin
				sm_raddr = ptr_q + LOG_WORDS'(k_q[2:0]);
				rb_raddr = ptr_q + LOG_WORDS'(k_q[2:0]);
				sm_re    = (k_q != 4'd8) && pass_q;
				rb_re    = (k_q != 4'd8) && !pass_q;
			end
			irbg_pkg::ST_RS_STORE: begin
				sm_we    = 1'b1;
				sm_waddr = ptr_q + LOG_WORDS'(k_q[2:0]);
				sm_wdata = v_q[k_q[2:0]];
			end
			irbg_pkg::ST_RD_X: sm_re = 1'b1;
			irbg_pkg::ST_RD_H: begin
				sm_re    = 1'b1;
				sm_raddr = ptr_q + HALF_W;
			end
			irbg_pkg::ST_RD_I: begin
				sm_re    = 1'b1;
				sm_raddr = x_q[LOG_WORDS+1:2];
			end
			irbg_pkg::ST_WR_Y: sm_we = 1'b1;
			irbg_pkg::ST_RD_Y: begin
				sm_re    = 1'b1;
				sm_raddr = y_q[2*LOG_WORDS+1:LOG_WORDS+2];
			end
			irbg_pkg::ST_WR_B: rb_we = 1'b1;
			irbg_pkg::ST_GEN_RD: begin
				rb_re    = (pos_q != POS_END);
				rb_raddr = pos_q[LOG_WORDS+1:2];
			end
			default: begin
			end
		endcase
	end

	// state and result buffer storage
	always_ff @(posedge clk) begin
		if (sm_we) sm_mem[sm_waddr] <= sm_wdata;
		if (sm_re) sm_rd_q <= sm_mem[sm_raddr];
		if (rb_we) rb_mem[rb_waddr] <= rb_wdata;
		if (rb_re) rb_rd_q <= rb_mem[rb_raddr];
	end

	// datapath and control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= irbg_pkg::ST_IDLE;
			rb_vld_q    <= '0;
			rb_rdv_q    <= 1'b0;
			a_q         <= '0;
			b_q         <= '0;
			rc_q        <= '0;
			pos_q       <= POS_END;
			out_valid_q <= 1'b0;
			ptr_q       <= '0;
			k_q         <= '0;
			mix_q       <= '0;
			pass_q      <= 1'b0;
			cnt_q       <= '0;
		end else begin
			state_q <= state_d;
			if (rb_we) rb_vld_q[rb_waddr] <= 1'b1;
			if (rb_re) rb_rdv_q <= rb_vld_q[rb_raddr];

			if (out_load) begin
				out_valid_q <= 1'b1;
				out_byte_q  <= 8'(rb_data >> {pos_q[1:0], 3'b000});
				out_last_q  <= (cnt_q == 7'd1);
				pos_q       <= pos_q + PW'(1);
				cnt_q       <= cnt_q - 7'd1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end

			case (state_q)
				irbg_pkg::ST_IDLE: begin
					seed_q <= seed_word;
					widx_q <= word_index[LOG_WORDS-1:0];
					cnt_q  <= cnt_in;
					mix_q  <= '0;
					if (in_acc && command == irbg_pkg::CMD_RESEED) begin
						a_q  <= '0;
						b_q  <= '0;
						rc_q <= '0;
						v_q  <= {8{irbg_pkg::GOLDEN}};
					end
				end
				irbg_pkg::ST_RS_INIT: begin
					v_q   <= irbg_pkg::mix_step(v_q, mix_q[2:0]);
					mix_q <= mix_q + 5'd1;
					k_q   <= '0;
					ptr_q <= '0;
					pass_q <= 1'b0;
				end
				irbg_pkg::ST_RS_LOAD: begin
					if (k_q != 4'd0) v_q[k_q[2:0] - 3'd1] <= v_q[k_q[2:0] - 3'd1] + src_data;
					k_q   <= (k_q == 4'd8) ? 4'd0 : k_q + 4'd1;
				end
				irbg_pkg::ST_RS_MIX: begin
					v_q   <= irbg_pkg::mix_step(v_q, mix_q[2:0]);
					mix_q <= mix_q + 5'd1;
				end
				irbg_pkg::ST_RS_STORE: begin
					k_q <= (k_q == 4'd7) ? 4'd0 : k_q + 4'd1;
					if (k_q == 4'd7) begin
						if (ptr_q == LAST_G) begin
							ptr_q  <= '0;
							pass_q <= 1'b1;
						end else begin
							ptr_q <= ptr_q + LOG_WORDS'(8);
						end
					end
				end
				irbg_pkg::ST_RND_START: begin
					rc_q  <= rc_q + 32'd1;
					b_q   <= b_q + rc_q + 32'd1;
					ptr_q <= '0;
				end
				irbg_pkg::ST_RD_H: x_q <= sm_rd_q;
				irbg_pkg::ST_RD_I: a_q <= irbg_pkg::round_mix(a_q, ptr_q[1:0]) + sm_rd_q;
				irbg_pkg::ST_WR_Y: y_q <= y_new;
				irbg_pkg::ST_WR_B: begin
					b_q   <= b_new;
					ptr_q <= ptr_q + LOG_WORDS'(1);
					if (ptr_q == LAST_W) pos_q <= '0;
				end
				default: begin
				end
			endcase
		end
	end

	// checks
	a_pos_range: assert property (@(posedge clk) disable iff (!arst_n) pos_q <= POS_END)
		else $error("byte position beyond buffer end");
	a_group_align: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == irbg_pkg::ST_RS_LOAD) |-> (ptr_q[2:0] == 3'd0))
		else $error("reseed group base not aligned");
	a_last_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(out_load && cnt_q == 7'd1) |=> (state_q == irbg_pkg::ST_IDLE && out_last_q))
		else $error("final byte did not end the request");
	a_gen_no_write: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == irbg_pkg::ST_GEN_OUT) |-> (!rb_we && !sm_we))
		else $error("memory write during byte output");

endmodule

[bench/isaac_checker.sv]
module isaac_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_stall,
	input  logic [1:0]  command,
	input  logic [31:0] seed_word,
	input  logic [7:0]  word_index,
	input  logic [6:0]  byte_count,
	input  logic        out_valid,
	input  logic        out_stall,
	input  logic [7:0]  data_byte,
	input  logic        last,
	output int          fail_count,
	output int          bytes_pending
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int NW = irbg_pkg::WORDS_DEF;
	localparam int NB = irbg_pkg::MAX_BURST_DEF;

	typedef struct packed {
		logic [7:0] data;
		logic       tail;
	} gen_byte_t;

	gen_byte_t   byte_q[$];
	logic [31:0] st_mem[NW];
	logic [31:0] res_buf[NW];
	logic [31:0] acc_a, acc_b, rounds;
	logic [10:0] byte_pos;
	logic [31:0] mv[8];

	// eight-word golden-ratio mix
	function automatic void mix_words();
		mv[0] ^= mv[1] << 11; mv[3] += mv[0]; mv[1] += mv[2];
		mv[1] ^= mv[2] >> 2;  mv[4] += mv[1]; mv[2] += mv[3];
		mv[2] ^= mv[3] << 8;  mv[5] += mv[2]; mv[3] += mv[4];
		mv[3] ^= mv[4] >> 16; mv[6] += mv[3]; mv[4] += mv[5];
		mv[4] ^= mv[5] << 10; mv[7] += mv[4]; mv[5] += mv[6];
		mv[5] ^= mv[6] >> 4;  mv[0] += mv[5]; mv[6] += mv[7];
		mv[6] ^= mv[7] << 8;  mv[1] += mv[6]; mv[7] += mv[0];
		mv[7] ^= mv[0] >> 9;  mv[2] += mv[7]; mv[0] += mv[1];
	endfunction

	// two-pass state init: first from the result buffer, then from itself
	function automatic void reseed_state();
		acc_a = '0;
		acc_b = '0;
		rounds = '0;
		for (int k = 0; k < 8; k++) mv[k] = irbg_pkg::GOLDEN;
		for (int k = 0; k < 4; k++) mix_words();
		for (int p = 0; p < 2; p++) begin
			for (int w = 0; w < NW; w += 8) begin
				for (int k = 0; k < 8; k++) mv[k] += (p == 0) ? res_buf[w + k] : st_mem[w + k];
				mix_words();
				for (int k = 0; k < 8; k++) st_mem[w + k] = mv[k];
			end
		end
	endfunction

	// one full round refills the result buffer
	function automatic void refill_buffer();
		logic [31:0] a, b, x, y, m;
		rounds = rounds + 1;
		a = acc_a;
		b = acc_b + rounds;
		for (int w = 0; w < NW; w++) begin
			case (w % 4)
				0: m = a << 13;
				1: m = a >> 6;
				2: m = a << 2;
				default: m = a >> 16;
			endcase
			x = st_mem[w];
			a = (a ^ m) + st_mem[(w + NW / 2) % NW];
			y = st_mem[(x >> 2) % NW] + a + b;
			st_mem[w] = y;
			b = st_mem[(y >> 10) % NW] + x;
			res_buf[w] = b;
		end
		acc_a = a;
		acc_b = b;
	endfunction

	function automatic void predict_bytes(logic [6:0] cnt_in);
		int cnt;
		gen_byte_t e;
		cnt = (cnt_in > NB) ? NB : cnt_in;
		for (int k = 0; k < cnt; k++) begin
			if (byte_pos >= NW * 4) begin
				refill_buffer();
				byte_pos = '0;
			end
			e.data = 8'(res_buf[byte_pos[9:2]] >> (8 * byte_pos[1:0]));
			e.tail = (k + 1 == cnt);
			byte_q.push_back(e);
			byte_pos = byte_pos + 11'd1;
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		gen_byte_t e;
		if (!arst_n) begin
			for (int w = 0; w < NW; w++) begin
				st_mem[w] = '0;
				res_buf[w] = '0;
			end
			acc_a = '0;
			acc_b = '0;
			rounds = '0;
			byte_pos = 11'(NW * 4);
			byte_q.delete();
			fail_count <= 0;
			bytes_pending <= 0;
		end else begin
			// input beat updates the prediction
			if (in_valid && !in_stall) begin
				case (command)
					irbg_pkg::CMD_SEED:   res_buf[word_index % NW] ^= seed_word;
					irbg_pkg::CMD_RESEED: reseed_state();
					irbg_pkg::CMD_GEN:    predict_bytes(byte_count);
					default: ;
				endcase
			end
			// output beat against oldest expected byte
			if (out_valid && !out_stall) begin
				if (byte_q.size() == 0) begin
					$error("unexpected byte beat: data_byte=%0h last=%0b", data_byte, last);
					fail_count <= fail_count + 1;
				end else begin
					e = byte_q.pop_front();
					if (data_byte !== e.data || last !== e.tail) begin
						if (data_byte !== e.data)
							$error("data_byte expected %0h actual %0h", e.data, data_byte);
						if (last !== e.tail)
							$error("last expected %0b actual %0b", e.tail, last);
						fail_count <= fail_count + 1;
					end
				end
			end
			bytes_pending <= byte_q.size();
		end
	end
endmodule

[bench/tb_top.sv]
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CYCLE_LIMIT = 1000000;
	localparam int N_RANDOM = 160;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [1:0]  command = irbg_pkg::CMD_SEED;
	logic [31:0] seed_word = '0;
	logic [7:0]  word_index = '0;
	logic [6:0]  byte_count = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [7:0]  data_byte;
	logic        last;
	int          fail_count;
	int          bytes_pending;
	int          cycles = 0;
	logic        quiet = 1'b0;
	logic        long_hold = 1'b0;

	isaac_random_byte_generator_top dut (.*);
	isaac_checker chk (.*);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// run limit
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	// receiver: random stall bursts, one long hold on request
	initial begin
		int n;
		forever begin
			@(negedge clk);
			if (long_hold) begin
				out_stall <= 1'b1;
				repeat (400) @(negedge clk);
				long_hold = 1'b0;
				out_stall <= 1'b0;
			end else if (!quiet && $urandom_range(5) == 0) begin
				n = $urandom_range(1, 8);
				out_stall <= 1'b1;
				repeat (n - 1) @(negedge clk);
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	task automatic send_beat(logic [1:0] cmd, logic [31:0] sw, logic [7:0] idx, logic [6:0] cnt);
		int n;
		@(negedge clk);
		if (!quiet && $urandom_range(4) == 0) begin
			n = $urandom_range(1, 8);
			in_valid <= 1'b0;
			repeat (n) @(negedge clk);
		end
		command <= cmd;
		seed_word <= sw;
		word_index <= idx;
		byte_count <= cnt;
		in_valid <= 1'b1;
		do @(posedge clk); while (in_stall);
	endtask

	initial begin
		int r;
		logic [1:0] cmd;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed: field extremes, ignored command, saturation, zero count
		send_beat(irbg_pkg::CMD_SEED, 32'hffffffff, 8'd0, 7'd0);
		send_beat(irbg_pkg::CMD_SEED, 32'h00000000, 8'd255, 7'd127);
		send_beat(irbg_pkg::CMD_SEED, 32'h80000001, 8'd128, 7'd64);
		send_beat(irbg_pkg::CMD_GEN, 32'hffffffff, 8'd255, 7'd0);
		send_beat(irbg_pkg::CMD_UNUSED, 32'hffffffff, 8'd255, 7'd127);
		send_beat(irbg_pkg::CMD_RESEED, 32'h0, 8'd0, 7'd0);
		send_beat(irbg_pkg::CMD_GEN, 32'h0, 8'd0, 7'd1);
		send_beat(irbg_pkg::CMD_GEN, 32'h0, 8'd0, 7'd64);
		send_beat(irbg_pkg::CMD_GEN, 32'h0, 8'd0, 7'd127);
		send_beat(irbg_pkg::CMD_GEN, 32'h0, 8'd0, 7'd65);
		send_beat(irbg_pkg::CMD_GEN, 32'h0, 8'd0, 7'd0);
		send_beat(irbg_pkg::CMD_UNUSED, 32'h0, 8'd0, 7'd5);
		send_beat(irbg_pkg::CMD_SEED, 32'h12345678, 8'd17, 7'd3);
		send_beat(irbg_pkg::CMD_RESEED, 32'h0, 8'd0, 7'd0);
		send_beat(irbg_pkg::CMD_GEN, 32'h0, 8'd0, 7'd3);
		// fill the block while the receiver holds off
		long_hold = 1'b1;
		for (int k = 0; k < 6; k++) send_beat(irbg_pkg::CMD_GEN, 32'h0, 8'd0, 7'd64);

		// random: mostly generates, with seeds and some reseeds
		for (int k = 0; k < N_RANDOM; k++) begin
			if (k == N_RANDOM - 30) quiet = 1'b1;
			r = $urandom_range(99);
			if (r < 55) cmd = irbg_pkg::CMD_GEN;
			else if (r < 88) cmd = irbg_pkg::CMD_SEED;
			else if (r < 96) cmd = irbg_pkg::CMD_RESEED;
			else cmd = irbg_pkg::CMD_UNUSED;
			send_beat(cmd, $urandom, 8'($urandom_range(255)),
				(r < 10) ? 7'($urandom_range(127)) : 7'($urandom_range(1, 64)));
		end
		@(negedge clk);
		in_valid <= 1'b0;

		wait (bytes_pending == 0);
		repeat (2000) @(posedge clk);
		if (fail_count == 0 && bytes_pending == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end
endmodule
